// ----- design/rmq_pkg.sv -----
// Shared constants and types for the rotation matrix to quaternion block.
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 30;
    localparam int ELEM_W  = 32;
    localparam int RAW_W   = 36;
    localparam int MAG_W   = 35;
    localparam int NMAG_W  = 31;
    localparam int SUM_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int ROOT_CELLS = 32;
    localparam int SHIFT_W = 6;

    typedef struct packed {
        logic [NMAG_W-1:0] mag0;
        logic [NMAG_W-1:0] mag1;
        logic [NMAG_W-1:0] mag2;
        logic [NMAG_W-1:0] mag3;
        logic [3:0]        neg;
        logic              degen;
    } vec_t;

endpackage

// ----- design/rmq_root_cell.sv -----
// One bit step of the pipelined integer square root.
module rmq_root_cell #(
    parameter int STEP = 0
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [rmq_pkg::SUM_W-1:0]  rem_in,
    input  logic [rmq_pkg::ROOT_W-1:0] root_in,
    input  rmq_pkg::vec_t              vec_in,
    output logic [rmq_pkg::SUM_W-1:0]  rem_out,
    output logic [rmq_pkg::ROOT_W-1:0] root_out,
    output rmq_pkg::vec_t              vec_out
);
    localparam int BITPOS = rmq_pkg::ROOT_W - 1 - STEP;

    logic [rmq_pkg::SUM_W:0] trial;
    logic [rmq_pkg::SUM_W:0] rem_ext;
    logic [rmq_pkg::ROOT_W-1:0] root_try;

    // growth of root^2 when this bit is set: root*2^(k+1) + 2^(2k)
    always_comb begin
        root_try = root_in | (rmq_pkg::ROOT_W'(1) << BITPOS);
        trial = ((rmq_pkg::SUM_W+1)'(root_in) << (BITPOS + 1))
              | ((rmq_pkg::SUM_W+1)'(1) << (2 * BITPOS));
        rem_ext = {1'b0, rem_in};
    end

    // rem_in carries what is left of the radicand; root grows one bit per cell
    always_ff @(posedge aclk) begin
        if (en) begin
            vec_out <= vec_in;
            if (trial <= rem_ext) begin
                rem_out <= rmq_pkg::SUM_W'(rem_ext - trial);
                root_out <= root_try;
            end else begin
                rem_out <= rem_in;
                root_out <= root_in;
            end
        end
    end
endmodule

// ----- design/rmq_div_cell.sv -----
// One quotient bit step of the four pipelined fraction dividers.
module rmq_div_cell (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [rmq_pkg::ROOT_W-1:0] den,
    input  logic [4*(rmq_pkg::ROOT_W+1)-1:0] rem_in,
    input  logic [4*rmq_pkg::ROOT_W-1:0]     q_in,
    input  logic [4:0]                 side_in,
    output logic [rmq_pkg::ROOT_W-1:0] den_out,
    output logic [4*(rmq_pkg::ROOT_W+1)-1:0] rem_out,
    output logic [4*rmq_pkg::ROOT_W-1:0]     q_out,
    output logic [4:0]                 side_out
);
    localparam int RW = rmq_pkg::ROOT_W + 1;
    localparam int QW = rmq_pkg::ROOT_W;

    logic [4*RW-1:0] rem_n;
    logic [4*QW-1:0] q_n;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            logic [RW:0] sh;
            sh = {rem_in[i*RW +: RW], 1'b0};
            if (sh >= {2'b00, den}) begin
                rem_n[i*RW +: RW] = RW'(sh - {2'b00, den});
                q_n[i*QW +: QW] = {q_in[i*QW +: QW-1], 1'b1};
            end else begin
                rem_n[i*RW +: RW] = RW'(sh);
                q_n[i*QW +: QW] = {q_in[i*QW +: QW-1], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_out <= den;
            rem_out <= rem_n;
            q_out <= q_n;
            side_out <= side_in;
        end
    end
endmodule

// ----- design/rotation_matrix_to_quaternion.sv -----
// Top level: matrix to unit quaternion pipeline.
// Usage: present a 3x3 Q-format rotation matrix on s_m00..s_m22 with
// s_valid; a beat moves when s_valid and s_ready are high at a clock edge.
// The unit quaternion comes out on m_quat_w/x/y/z with m_degenerate, one
// beat per input beat, in order, on m_valid/m_ready.
// The pipeline has 5 + 32 + FRAC_BITS + 1 register stages (68 at FRAC_BITS = 30):
// five front stages, the 32 square-root cells, one divider cell per
// fraction bit and the output register.
// Throughput: one matrix per cycle while the output is not stalled; every stage advances together.
// When the receiver stalls, the whole pipeline holds (s_ready follows
// m_ready when the output register is full), so no beat is lost.
// Reset (aresetn low, synchronous) clears all valid bits; payloads
// need no reset.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [31:0] s_m00, s_m01, s_m02,
    input  logic signed [31:0] s_m10, s_m11, s_m12,
    input  logic signed [31:0] s_m20, s_m21, s_m22,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [30:0] m_quat_w,
    output logic signed [31:0] m_quat_x, m_quat_y, m_quat_z,
    output logic        m_degenerate
);
    // raw components need room for ONE plus three full-scale elements
    localparam int RW = (FRAC_BITS + 3 > rmq_pkg::RAW_W) ? FRAC_BITS + 3 : rmq_pkg::RAW_W;
    localparam int MW = RW - (rmq_pkg::RAW_W - rmq_pkg::MAG_W);
    localparam int NW = rmq_pkg::NMAG_W;
    localparam int QW = rmq_pkg::ROOT_W;
    localparam int DC = FRAC_BITS;
    localparam int NSTG = 5 + rmq_pkg::ROOT_CELLS + DC;

    logic en;
    logic [NSTG-1:0] vld_reg;
    assign en = !m_valid || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[NSTG-2:0], s_valid};
    end

    // stage 1: branch and raw components
    logic signed [RW-1:0] raw_reg [4];
    logic signed [RW-1:0] r_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            logic signed [RW-1:0] a0, a1, a2, a4, a5, a6, a8, a7, a3, one, tr;
            a0 = RW'(s_m00); a1 = RW'(s_m01); a2 = RW'(s_m02);
            a3 = RW'(s_m10); a4 = RW'(s_m11); a5 = RW'(s_m12);
            a6 = RW'(s_m20); a7 = RW'(s_m21); a8 = RW'(s_m22);
            one = RW'(1) <<< FRAC_BITS;
            tr = a0 + a4 + a8;
            priority if (tr > 0) begin
                r_reg <= one + tr;
                raw_reg[0] <= one + tr; raw_reg[1] <= a7 - a5;
                raw_reg[2] <= a2 - a6; raw_reg[3] <= a3 - a1;
            end else if (a0 > a4 && a0 > a8) begin
                r_reg <= one + a0 - a4 - a8;
                raw_reg[0] <= a7 - a5; raw_reg[1] <= one + a0 - a4 - a8;
                raw_reg[2] <= a1 + a3; raw_reg[3] <= a2 + a6;
            end else if (a4 > a8) begin
                r_reg <= one + a4 - a0 - a8;
                raw_reg[0] <= a2 - a6; raw_reg[1] <= a1 + a3;
                raw_reg[2] <= one + a4 - a0 - a8; raw_reg[3] <= a5 + a7;
            end else begin
                r_reg <= one + a8 - a0 - a4;
                raw_reg[0] <= a3 - a1; raw_reg[1] <= a2 + a6;
                raw_reg[2] <= a5 + a7; raw_reg[3] <= one + a8 - a0 - a4;
            end
        end
    end

    // stage 2: magnitudes and common shift
    logic [MW-1:0] mag_reg [4];
    logic [3:0] neg2_reg;
    logic degen2_reg;
    logic [rmq_pkg::SHIFT_W-1:0] lz_reg;
    logic right2_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            logic [MW-1:0] m [4];
            logic [MW-1:0] big;
            logic [3:0] ng;
            logic [rmq_pkg::SHIFT_W-1:0] sh;
            big = '0;
            for (int i = 0; i < 4; i++) begin
                m[i] = MW'(raw_reg[i] < 0 ? -raw_reg[i] : raw_reg[i]);
                if (m[i] > big) big = m[i];
                ng[i] = (raw_reg[i] < 0) != (raw_reg[0] < 0);
            end
            right2_reg <= big[MW-1:31] != '0;
            sh = '0;
            for (int b = 0; b < MW; b++)
                if (big[b]) sh = (b >= 31) ? rmq_pkg::SHIFT_W'(b - 30)
                                           : rmq_pkg::SHIFT_W'(30 - b);
            lz_reg <= sh;
            for (int i = 0; i < 4; i++) mag_reg[i] <= m[i];
            neg2_reg <= ng;
            degen2_reg <= r_reg <= 0;
        end
    end

    // stage 3: apply shift
    logic [NW-1:0] nm_reg [4];
    logic [3:0] neg3_reg;
    logic degen3_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++)
                nm_reg[i] <= right2_reg ? NW'(mag_reg[i] >> lz_reg)
                                        : NW'(mag_reg[i] << lz_reg);
            neg3_reg <= neg2_reg;
            degen3_reg <= degen2_reg;
        end
    end

    // stage 4: sum of squares (products registered before the add)
    logic [2*NW-1:0] sq_reg [4];
    rmq_pkg::vec_t v4_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) sq_reg[i] <= nm_reg[i] * nm_reg[i];
            v4_reg <= '{nm_reg[0], nm_reg[1], nm_reg[2], nm_reg[3],
                        neg3_reg, degen3_reg};
        end
    end
    logic [rmq_pkg::SUM_W-1:0] sum_reg;
    rmq_pkg::vec_t v5_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= rmq_pkg::SUM_W'(sq_reg[0]) + rmq_pkg::SUM_W'(sq_reg[1])
                     + rmq_pkg::SUM_W'(sq_reg[2]) + rmq_pkg::SUM_W'(sq_reg[3]);
            v5_reg <= v4_reg;
        end
    end

    // square root chain
    logic [rmq_pkg::SUM_W-1:0] rr [rmq_pkg::ROOT_CELLS+1];
    logic [QW-1:0] rt [rmq_pkg::ROOT_CELLS+1];
    rmq_pkg::vec_t rv [rmq_pkg::ROOT_CELLS+1];
    assign rr[0] = sum_reg;
    assign rt[0] = '0;
    assign rv[0] = v5_reg;
    for (genvar g = 0; g < rmq_pkg::ROOT_CELLS; g++) begin : g_root
        rmq_root_cell #(.STEP(g)) u_cell (
            .aclk(aclk), .en(en), .rem_in(rr[g]), .root_in(rt[g]), .vec_in(rv[g]),
            .rem_out(rr[g+1]), .root_out(rt[g+1]), .vec_out(rv[g+1])
        );
    end

    // divider chain; initial quotient bit from a >= n
    logic [QW-1:0] dd [DC+1];
    logic [4*(QW+1)-1:0] dr [DC+1];
    logic [4*QW-1:0] dq [DC+1];
    logic [4:0] ds [DC+1];
    logic [NW-1:0] amag [4];
    logic [4*(QW+1)-1:0] dr0;
    logic [4*QW-1:0] dq0;
    assign amag[0] = rv[rmq_pkg::ROOT_CELLS].mag0;
    assign amag[1] = rv[rmq_pkg::ROOT_CELLS].mag1;
    assign amag[2] = rv[rmq_pkg::ROOT_CELLS].mag2;
    assign amag[3] = rv[rmq_pkg::ROOT_CELLS].mag3;
    assign dd[0] = (rt[rmq_pkg::ROOT_CELLS] == '0) ? QW'(1) : rt[rmq_pkg::ROOT_CELLS];
    assign ds[0] = {rv[rmq_pkg::ROOT_CELLS].neg, rv[rmq_pkg::ROOT_CELLS].degen};
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if ({1'b0, amag[i]} >= dd[0]) begin
                dr0[i*(QW+1) +: QW+1] = (QW+1)'({2'b00, amag[i]} - {1'b0, dd[0]});
                dq0[i*QW +: QW] = QW'(1);
            end else begin
                dr0[i*(QW+1) +: QW+1] = (QW+1)'(amag[i]);
                dq0[i*QW +: QW] = '0;
            end
        end
    end
    assign dr[0] = dr0;
    assign dq[0] = dq0;
    for (genvar g = 0; g < DC; g++) begin : g_div
        rmq_div_cell u_cell (
            .aclk(aclk), .en(en), .den(dd[g]), .rem_in(dr[g]), .q_in(dq[g]),
            .side_in(ds[g]), .den_out(dd[g+1]), .rem_out(dr[g+1]),
            .q_out(dq[g+1]), .side_out(ds[g+1])
        );
    end

    // final: round, sign, degenerate clear, output register
    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid <= 1'b0;
        else if (en) m_valid <= vld_reg[NSTG-1];
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            logic [QW-1:0] q [4];
            logic [QW:0] rm;
            for (int i = 0; i < 4; i++) begin
                rm = dr[DC][i*(QW+1) +: QW+1];
                q[i] = dq[DC][i*QW +: QW];
                if ({rm, 1'b0} >= {2'b00, dd[DC]}) q[i] = q[i] + QW'(1);
                if (ds[DC][i+1] && q[i] != '0) q[i] = -q[i];
                if (ds[DC][0]) q[i] = '0;
            end
            m_quat_w <= q[0][30:0];
            m_quat_x <= q[1];
            m_quat_y <= q[2];
            m_quat_z <= q[3];
            m_degenerate <= ds[DC][0];
        end
    end
endmodule

// ----- dv/tb_top.sv -----
// Testbench for the rotation matrix to quaternion pipeline: random and directed matrices.
`timescale 1ns / 100ps

class quat_scoreboard;
    logic [30:0] exp_w[$];
    logic [31:0] exp_x[$], exp_y[$], exp_z[$];
    logic        exp_dg[$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    static function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // round(a * 2^30 / n), half up
    static function longint unsigned scaled_div(longint unsigned a, longint unsigned n);
        longint unsigned q, rem;
        q = 0;
        rem = a;
        if (rem >= n) begin
            q = 1;
            rem = rem - n;
        end
        for (int i = 0; i < 30; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= n) begin
                rem = rem - n;
                q = q | 1;
            end
        end
        if ((rem << 1) >= n) q = q + 1;
        return q;
    endfunction

    // queue one expected result beat
    function void add_exp(logic [30:0] w, logic [31:0] x, logic [31:0] y,
                          logic [31:0] z, logic dg);
        exp_w.insert(exp_w.size(), w);
        exp_x.insert(exp_x.size(), x);
        exp_y.insert(exp_y.size(), y);
        exp_z.insert(exp_z.size(), z);
        exp_dg.insert(exp_dg.size(), dg);
    endfunction

    function void note_matrix(logic signed [31:0] e[9]);
        longint m[9];
        longint tr, r;
        longint raw[4];
        longint unsigned mag[4], big, sum, n, v;
        bit flip, neg;
        logic [31:0] q[4];
        for (int i = 0; i < 9; i++) m[i] = e[i];
        tr = m[0] + m[4] + m[8];
        big = 0;
        sum = 0;
        if (tr > 0) begin
            r = (64'sd1 << 30) + tr;
            raw[0] = r; raw[1] = m[7] - m[5]; raw[2] = m[2] - m[6]; raw[3] = m[3] - m[1];
        end else if (m[0] > m[4] && m[0] > m[8]) begin
            r = (64'sd1 << 30) + m[0] - m[4] - m[8];
            raw[0] = m[7] - m[5]; raw[1] = r; raw[2] = m[1] + m[3]; raw[3] = m[2] + m[6];
        end else if (m[4] > m[8]) begin
            r = (64'sd1 << 30) + m[4] - m[0] - m[8];
            raw[0] = m[2] - m[6]; raw[1] = m[1] + m[3]; raw[2] = r; raw[3] = m[5] + m[7];
        end else begin
            r = (64'sd1 << 30) + m[8] - m[0] - m[4];
            raw[0] = m[3] - m[1]; raw[1] = m[2] + m[6]; raw[2] = m[5] + m[7]; raw[3] = r;
        end
        if (r <= 0) begin
            add_exp('0, '0, '0, '0, 1'b1);
            return;
        end
        for (int i = 0; i < 4; i++) begin
            mag[i] = raw[i] < 0 ? -raw[i] : raw[i];
            if (mag[i] > big) big = mag[i];
        end
        while (big >= (64'd1 << 31)) begin
            big = big >> 1;
            for (int i = 0; i < 4; i++) mag[i] = mag[i] >> 1;
        end
        while (big < (64'd1 << 30)) begin
            big = big << 1;
            for (int i = 0; i < 4; i++) mag[i] = mag[i] << 1;
        end
        for (int i = 0; i < 4; i++) sum = sum + mag[i] * mag[i];
        n = int_sqrt(sum);
        flip = raw[0] < 0;
        for (int i = 0; i < 4; i++) begin
            v = scaled_div(mag[i], n);
            neg = (raw[i] < 0) != flip;
            if (neg && v != 0) v = -v;
            q[i] = v[31:0];
        end
        add_exp(q[0][30:0], q[1], q[2], q[3], 1'b0);
    endfunction

    function void check_quat(logic [30:0] w, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic dg);
        logic [30:0] ew;
        logic [31:0] ex, ey, ez;
        logic        ed;
        if (exp_w.size() == 0) begin
            $error("unexpected result beat");
            errors++;
            return;
        end
        ew = exp_w.pop_front(); ex = exp_x.pop_front(); ey = exp_y.pop_front();
        ez = exp_z.pop_front(); ed = exp_dg.pop_front();
        if (w !== ew) begin $error("quat_w exp %h got %h", ew, w); errors++; end
        if (x !== ex) begin $error("quat_x exp %h got %h", ex, x); errors++; end
        if (y !== ey) begin $error("quat_y exp %h got %h", ey, y); errors++; end
        if (z !== ez) begin $error("quat_z exp %h got %h", ez, z); errors++; end
        if (dg !== ed) begin $error("degenerate exp %b got %b", ed, dg); errors++; end
    endfunction

    function int pending();
        return exp_w.size();
    endfunction
endclass

module tb_top;
    localparam int LATENCY = 5 + 32 + 31 + 2;
    localparam logic signed [31:0] ONE = 32'sd1073741824;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_m[9];
    logic m_valid;
    logic m_ready = 1'b0;
    logic [30:0] m_quat_w;
    logic signed [31:0] m_quat_x, m_quat_y, m_quat_z;
    logic m_degenerate;
    bit stall_long = 1'b0;

    quat_scoreboard sb = new();

    always #10 aclk = ~aclk;

    rotation_matrix_to_quaternion dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_m00(s_m[0]), .s_m01(s_m[1]), .s_m02(s_m[2]),
        .s_m10(s_m[3]), .s_m11(s_m[4]), .s_m12(s_m[5]),
        .s_m20(s_m[6]), .s_m21(s_m[7]), .s_m22(s_m[8]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_quat_w(m_quat_w), .m_quat_x(m_quat_x), .m_quat_y(m_quat_y),
        .m_quat_z(m_quat_z), .m_degenerate(m_degenerate)
    );

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one matrix beat and hold it until accepted; drop valid during a gap.
    task automatic send_matrix(logic signed [31:0] e[9]);
        int g;
        g = gap_len();
        if (g != 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        for (int i = 0; i < 9; i++) s_m[i] <= e[i];
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_matrix(e);
    endtask

    // Random rotation-like matrix: a permutation with signs, perturbed.
    task automatic make_rotation(output logic signed [31:0] e[9]);
        int perm[3];
        int t, k, sgn;
        perm = '{0, 1, 2};
        for (int i = 2; i > 0; i--) begin
            k = $urandom_range(0, i);
            t = perm[i]; perm[i] = perm[k]; perm[k] = t;
        end
        for (int i = 0; i < 9; i++) e[i] = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
        for (int i = 0; i < 3; i++) begin
            sgn = $urandom_range(0, 1);
            e[3 * i + perm[i]] = sgn ? -ONE + $urandom_range(0, 1 << 27)
                                     : ONE - $urandom_range(0, 1 << 27);
        end
    endtask

    // Receiver: random stalls plus one long hold-off.
    initial begin
        int g;
        bit stalled;
        stalled = 1'b0;
        m_ready <= 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (stall_long && !stalled) begin
                stalled = 1'b1;
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
            end
            g = gap_len();
            if (g != 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk)
        if (aresetn && m_valid && m_ready)
            sb.check_quat(m_quat_w, m_quat_x, m_quat_y, m_quat_z, m_degenerate);

    initial begin
        logic signed [31:0] e[9];
        int waited;
        for (int i = 0; i < 9; i++) s_m[i] = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // identity, each diagonal-dominant branch, degenerate, extremes
        e = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};              send_matrix(e);
        e = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};            send_matrix(e);
        e = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE};            send_matrix(e);
        e = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE};            send_matrix(e);
        e = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};           send_matrix(e);
        e = '{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE};             send_matrix(e);
        e = '{0, ONE, 0, -ONE, 0, 0, 0, 0, -ONE};            send_matrix(e);
        e = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE - 5};       send_matrix(e);
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                    send_matrix(e);
        for (int i = 0; i < 9; i++) e[i] = 32'sh7fffffff;     send_matrix(e);
        for (int i = 0; i < 9; i++) e[i] = 32'sh80000000;     send_matrix(e);
        e = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
              32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000}; send_matrix(e);
        e = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
              32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000}; send_matrix(e);
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 1};                    send_matrix(e);
        e = '{-ONE, 1, 0, 0, -ONE, 0, 0, 0, ONE};            send_matrix(e);
        for (int n = 0; n < 1600; n++) begin
            if (n == 400) stall_long = 1'b1;
            case ($urandom_range(0, 9))
                0, 1: for (int i = 0; i < 9; i++) e[i] = $urandom();
                2:    for (int i = 0; i < 9; i++)
                          e[i] = $signed($urandom_range(0, 1 << 31)) - ONE;
                default: make_rotation(e);
            endcase
            send_matrix(e);
        end
        s_valid <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
